// ===== rtl/tbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Tolerance box classifier package
// Shared constants, codes, record types and the absolute difference helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tbc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int LEN_W   = 16;
  localparam int COL_W   = 8;
  localparam int DENS_W  = 16;
  localparam int ANGLE_W = 16;
  localparam int SLOT_W  = 4;
  localparam int IDX_W   = 4;
  localparam int USE_W   = 5;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 16;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_WIDTH_TOL   = 3'd0,
    CFG_HEIGHT_TOL  = 3'd1,
    CFG_HUE_TOL     = 3'd2,
    CFG_SAT_TOL     = 3'd3,
    CFG_VAL_TOL     = 3'd4,
    CFG_DENSITY_TOL = 3'd5,
    CFG_ENTRIES     = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_t;

  // Features compared against one reference entry.
  typedef struct packed {
    logic [LEN_W-1:0]  width;
    logic [LEN_W-1:0]  height;
    logic [COL_W-1:0]  hue;
    logic [COL_W-1:0]  sat;
    logic [COL_W-1:0]  val;
    logic [DENS_W-1:0] density;
  } feat_t;

  typedef struct packed {
    feat_t feat;
    logic  zero_ang;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [LEN_W-1:0]  width;
    logic [LEN_W-1:0]  height;
    logic [COL_W-1:0]  hue;
    logic [COL_W-1:0]  sat;
    logic [COL_W-1:0]  val;
    logic [DENS_W-1:0] density;
  } tol_t;

  function automatic logic [LEN_W-1:0] abs_diff16(input logic [LEN_W-1:0] a,
                                                  input logic [LEN_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [COL_W-1:0] abs_diff8(input logic [COL_W-1:0] a,
                                                 input logic [COL_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tbc_if.sv =====
// ----------------------------------------------------------------------------
// Tolerance box classifier channels
// Valid/ready interfaces for the request, result and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [3:0]                entry_index;
  logic [15:0]               rect_width;
  logic [15:0]               rect_height;
  logic [7:0]                hue;
  logic [7:0]                saturation;
  logic [7:0]                brightness;
  logic [15:0]               density;
  logic signed [15:0]        angle;
  logic                      zero_orientation;

  modport source (output valid, command, entry_index, rect_width, rect_height, hue,
                  saturation, brightness, density, angle, zero_orientation,
                  input ready);
  modport sink (input valid, command, entry_index, rect_width, rect_height, hue,
                saturation, brightness, density, angle, zero_orientation,
                output ready);
endinterface

interface tbc_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic [3:0]         match_index;
  logic signed [15:0] angle_out;

  modport source (output valid, found, match_index, angle_out, input ready);
  modport sink (input valid, found, match_index, angle_out, output ready);
endinterface

interface tbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tbc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tbc_match.sv =====
// ----------------------------------------------------------------------------
// Tolerance box compare unit
// Checks one reference entry against the query features, all six at once.
// ----------------------------------------------------------------------------
`default_nettype none

module tbc_match
  import tbc_pkg::*;
(
  input  wire feat_t q,
  input  wire feat_t ref_feat,
  input  wire tol_t  tol,
  output logic       hit
);

  logic w_ok, h_ok, hue_ok, sat_ok, val_ok, d_ok;

  always_comb begin
    w_ok   = abs_diff16(q.width, ref_feat.width) <= tol.width;
    h_ok   = abs_diff16(q.height, ref_feat.height) <= tol.height;
    hue_ok = abs_diff8(q.hue, ref_feat.hue) <= tol.hue;
    sat_ok = abs_diff8(q.sat, ref_feat.sat) <= tol.sat;
    val_ok = abs_diff8(q.val, ref_feat.val) <= tol.val;
    d_ok   = abs_diff16(q.density, ref_feat.density) <= tol.density;
    hit    = w_ok & h_ok & hue_ok & sat_ok & val_ok & d_ok;
  end

endmodule

`default_nettype wire

// ===== rtl/tolerance_box_object_classifier.sv =====
// ----------------------------------------------------------------------------
// Tolerance box object classifier
// Holds a table of reference objects and finds the first one that matches a
// detected rectangle within per-feature tolerances.
// ----------------------------------------------------------------------------
//   channel  dir  handshake       contents
//   in_if    in   valid/ready     load or query request
//   out_if   out  valid/ready     found, match_index, angle_out (queries only)
//   cfg_if   in   valid/ready     register index and write data
//
// A load is taken while idle and leaves the block idle. A query holds off new
// requests until its result is loaded and scans up to N entries, where N is entries_in_use capped at 16: one
// table read per cycle through the single RAM read port, each compared in the next cycle.
// Reset is synchronous and active low; the table itself is not cleared.
// A result waiting in the output register stalls only a later query's finish.
// Register writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tolerance_box_object_classifier
  import tbc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  tbc_in_if.sink    in_if,
  tbc_out_if.source out_if,
  tbc_cfg_if.sink   cfg_if
);

  state_t state_r, state_nxt;

  tol_t             tol_r;
  logic [USE_W-1:0] entries_r;

  feat_t               q_r;
  logic [ANGLE_W-1:0]  q_ang_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    rd_idx_r;
  logic                cmp_vld_r;
  logic [ADDR_W-1:0]   cmp_idx_r;

  logic                res_found_r;
  logic [IDX_W-1:0]    res_idx_r;
  logic [ANGLE_W-1:0]  res_ang_r;

  logic                out_valid_r;
  logic                out_found_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic [ANGLE_W-1:0]  out_ang_r;

  logic                in_acc, load_acc, query_acc;
  logic                rd_issue, hit, hit_now, last_cmp, decide, out_free, out_load;
  logic                ram_we;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              wr_entry, rd_entry;
  feat_t               in_feat;
  logic [CNT_W-1:0]    cnt_clamp;
  logic                dec_found;
  logic [IDX_W-1:0]    dec_idx;
  logic [ANGLE_W-1:0]  dec_ang;

  // Request side.
  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid & in_if.ready;
  assign load_acc     = in_acc & (in_if.command == CMD_LOAD);
  assign query_acc    = in_acc & (in_if.command == CMD_QUERY);

  assign in_feat.width   = in_if.rect_width;
  assign in_feat.height  = in_if.rect_height;
  assign in_feat.hue     = in_if.hue;
  assign in_feat.sat     = in_if.saturation;
  assign in_feat.val     = in_if.brightness;
  assign in_feat.density = in_if.density;

  assign wr_entry.feat     = in_feat;
  assign wr_entry.zero_ang = in_if.zero_orientation;
  assign ram_we = load_acc & (32'(in_if.entry_index) < MAX_ENTRIES);

  assign cnt_clamp = (32'(entries_r) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                    : CNT_W'(entries_r);

  tbc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_if.entry_index)),
    .wdata (wr_entry),
    .re    (rd_issue),
    .raddr (rd_idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  tbc_match u_match (
    .q        (q_r),
    .ref_feat (rd_entry.feat),
    .tol      (tol_r),
    .hit      (hit)
  );

  // The scan stops at the first hit or after the last entry has been compared.
  assign hit_now  = cmp_vld_r & hit;
  assign last_cmp = cmp_vld_r & ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == cnt_r);
  assign decide   = (state_r == ST_SCAN) & ((cnt_r == '0) | hit_now | last_cmp);
  assign rd_issue = (state_r == ST_SCAN) & (rd_idx_r < cnt_r) & ~decide;

  assign dec_found = hit_now;
  assign dec_idx   = hit_now ? IDX_W'(cmp_idx_r) : '0;
  assign dec_ang   = (hit_now & ~rd_entry.zero_ang) ? q_ang_r : '0;

  assign out_free = ~out_valid_r | out_if.ready;

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (query_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (decide) begin
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Tolerance and count registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r.width   <= 16'd66;
      tol_r.height  <= 16'd66;
      tol_r.hue     <= 8'd20;
      tol_r.sat     <= 8'd20;
      tol_r.val     <= 8'd20;
      tol_r.density <= 16'd5120;
      entries_r     <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_WIDTH_TOL:   tol_r.width   <= cfg_if.data[LEN_W-1:0];
        CFG_HEIGHT_TOL:  tol_r.height  <= cfg_if.data[LEN_W-1:0];
        CFG_HUE_TOL:     tol_r.hue     <= cfg_if.data[COL_W-1:0];
        CFG_SAT_TOL:     tol_r.sat     <= cfg_if.data[COL_W-1:0];
        CFG_VAL_TOL:     tol_r.val     <= cfg_if.data[COL_W-1:0];
        CFG_DENSITY_TOL: tol_r.density <= cfg_if.data[DENS_W-1:0];
        CFG_ENTRIES:     entries_r     <= cfg_if.data[USE_W-1:0];
        default: ;
      endcase
    end
  end

  // Scan control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else if (query_acc) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      q_r      <= in_feat;
      q_ang_r  <= in_if.angle;
      cnt_r    <= cnt_clamp;
      rd_idx_r <= '0;
    end else if (rd_issue) begin
      rd_idx_r  <= rd_idx_r + CNT_W'(1);
      cmp_idx_r <= rd_idx_r[ADDR_W-1:0];
    end
    if (decide) begin
      res_found_r <= dec_found;
      res_idx_r   <= dec_idx;
      res_ang_r   <= dec_ang;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state_r == ST_SCAN) begin
        out_found_r <= dec_found;
        out_idx_r   <= dec_idx;
        out_ang_r   <= dec_ang;
      end else begin
        out_found_r <= res_found_r;
        out_idx_r   <= res_idx_r;
        out_ang_r   <= res_ang_r;
      end
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.found       = out_found_r;
  assign out_if.match_index = out_idx_r;
  assign out_if.angle_out   = out_ang_r;

  // A miss carries a zero index and a zero angle.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_idx_r == '0 && out_ang_r == '0))
    else $error("miss result carries a nonzero index or angle");

  // A compare never looks past the capped entry count.
  a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (CNT_W'(cmp_idx_r) < cnt_r))
    else $error("compare beyond the searched entries");

  // An accepted query always starts a scan.
  a_query_scan: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |=> (state_r == ST_SCAN))
    else $error("query did not start a scan");

  // A new result never overwrites one that has not been taken.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_valid_r) |-> out_if.ready)
    else $error("result overwritten before it was taken");

  // Loads never write while a scan is reading the table.
  a_no_load_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !cmp_vld_r && (state_r == ST_IDLE))
    else $error("table written during a scan");

endmodule

`default_nettype wire
